// File: sv/alr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared constants for the anti-aliased line rasterizer.
// No dependencies; alr_front and alr_checker refer to it by scoped names.
package alr_pkg;

  typedef logic req_t;

  localparam req_t REQ_START = 1'b0;
  localparam req_t REQ_TICK  = 1'b1;

endpackage
`default_nettype wire

// File: sv/alr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces: input word, internal command word, pixel word.
// Depends on nothing; widths follow the parameters given at instantiation.
interface alr_in_if #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_finish;
  logic [COORD_BITS-1:0] y_finish;
  logic [COLOR_BITS-1:0] red_in;
  logic [COLOR_BITS-1:0] green_in;
  logic [COLOR_BITS-1:0] blue_in;

  modport source (output valid, req_type, x_start, y_start, x_finish, y_finish,
                  red_in, green_in, blue_in, input ready);
  modport sink (input valid, req_type, x_start, y_start, x_finish, y_finish,
                red_in, green_in, blue_in, output ready);
endinterface

interface alr_cmd_if #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic                  is_start;
  logic                  steep;
  logic [COORD_BITS-1:0] a0;
  logic [COORD_BITS-1:0] b0;
  logic [COORD_BITS-1:0] a1;
  logic [COORD_BITS-1:0] b1;
  logic [COORD_BITS-1:0] dmaj;
  logic                  dmin_neg;
  logic [COORD_BITS-1:0] dmin_abs;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;

  modport source (output valid, is_start, steep, a0, b0, a1, b1, dmaj, dmin_neg,
                  dmin_abs, red, green, blue, input ready);
  modport sink (input valid, is_start, steep, a0, b0, a1, b1, dmaj, dmin_neg,
                dmin_abs, red, green, blue, output ready);
endinterface

interface alr_out_if #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS:0]   pixel_x;
  logic [COORD_BITS:0]   pixel_y;
  logic [COLOR_BITS-1:0] red_out;
  logic [COLOR_BITS-1:0] green_out;
  logic [COLOR_BITS-1:0] blue_out;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                last_pixel, output ready);
endinterface
`default_nettype wire

// File: sv/alr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts input words, orders endpoints along the major axis,
// and queues command words for the back end. Uses alr_pkg and alr_if.
module alr_front #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 8
) (
  input  wire           clk,
  input  wire           rst_n,
  alr_in_if.sink        in_port,
  alr_cmd_if.source     cmd_port
);

  localparam int CB = COORD_BITS;
  localparam int EW = 3 + 6 * CB + 3 * COLOR_BITS;
  localparam int DEPTH = 2;

  logic [CB-1:0] adx, ady, sa0, sb0, sa1, sb1, a0, b0, a1, b1, dmaj, dmin_abs;
  logic          steep, swap, dmin_neg, push, pop;
  logic [EW-1:0] wr_word, rd_word;

  logic [EW-1:0] mem_r [DEPTH];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  always_comb begin
    adx = (in_port.x_finish >= in_port.x_start) ? in_port.x_finish - in_port.x_start
                                                : in_port.x_start - in_port.x_finish;
    ady = (in_port.y_finish >= in_port.y_start) ? in_port.y_finish - in_port.y_start
                                                : in_port.y_start - in_port.y_finish;
    steep = !(adx > ady);
    sa0 = steep ? in_port.y_start  : in_port.x_start;
    sb0 = steep ? in_port.x_start  : in_port.y_start;
    sa1 = steep ? in_port.y_finish : in_port.x_finish;
    sb1 = steep ? in_port.x_finish : in_port.y_finish;
    // step along rising major coordinate
    swap = sa1 < sa0;
    a0 = swap ? sa1 : sa0;
    b0 = swap ? sb1 : sb0;
    a1 = swap ? sa0 : sa1;
    b1 = swap ? sb0 : sb1;
    dmaj = a1 - a0;
    dmin_neg = b1 < b0;
    dmin_abs = dmin_neg ? b0 - b1 : b1 - b0;
    wr_word = {in_port.req_type == alr_pkg::REQ_START, steep, a0, b0, a1, b1, dmaj,
               dmin_neg, dmin_abs, in_port.red_in, in_port.green_in, in_port.blue_in};
  end

  assign in_port.ready  = count_r != 2'(DEPTH);
  assign cmd_port.valid = count_r != 2'd0;
  assign push = in_port.valid && in_port.ready;
  assign pop  = cmd_port.valid && cmd_port.ready;
  assign rd_word = mem_r[rd_ptr_r];

  assign {cmd_port.is_start, cmd_port.steep, cmd_port.a0, cmd_port.b0, cmd_port.a1,
          cmd_port.b1, cmd_port.dmaj, cmd_port.dmin_neg, cmd_port.dmin_abs,
          cmd_port.red, cmd_port.green, cmd_port.blue} = rd_word;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: sv/alr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: bit-serial gradient divider, line stepping state and pixel output
// register. Takes command words from alr_front; uses alr_if.
module alr_back #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16,
  parameter int COLOR_BITS = 8
) (
  input  wire           clk,
  input  wire           rst_n,
  alr_cmd_if.sink       cmd_port,
  alr_out_if.source     out_port
);

  localparam int CB   = COORD_BITS;
  localparam int PW   = CB + 1;
  localparam int IW   = PW + FRAC_BITS;
  localparam int SW   = FRAC_BITS + 2;
  localparam int DW   = CB + FRAC_BITS;
  localparam int CVW  = FRAC_BITS + 1;
  localparam int KW   = COLOR_BITS;
  localparam int CNTW = $clog2(DW + 1);
  localparam logic [CVW-1:0] COV_ONE  = CVW'(1) << FRAC_BITS;
  localparam logic [CVW-1:0] COV_HALF = CVW'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t          state_r;
  logic            active_r, steep_r, is_start_r, neg_r, tlast_r, out_valid_r;
  logic [PW-1:0]   pos_r, stop_r, tpos_r, ip_r;
  logic [IW-1:0]   icpt_r;
  logic [SW-1:0]   slope_r;
  logic [FRAC_BITS-1:0] fr_r;
  logic [CB-1:0]   a0_r, b0_r, a1_r, b1_r, dmaj_r;
  logic [KW-1:0]   red_r, green_r, blue_r;
  logic [CB:0]     rem_r;
  logic [DW-1:0]   quo_r;
  logic [CNTW-1:0] cnt_r;
  logic [1:0]      k_r;
  logic [PW-1:0]   px_r, py_r;
  logic [KW-1:0]   ro_r, go_r, bo_r;
  logic            lo_r;

  logic [CB:0]     rem_sh;
  logic            qbit, out_free, pix_last, slot_done;
  logic [SW-1:0]   q_fin, s_fin;
  logic [IW-1:0]   slope_ext, s_fin_ext;
  logic [PW-1:0]   maj, mnr, pos_inc;
  logic [CVW-1:0]  cov;
  logic [KW+CVW-1:0] prod_r, prod_g, prod_b;

  always_comb begin
    rem_sh = {rem_r[CB-1:0], quo_r[DW-1]};
    qbit   = rem_sh >= {1'b0, dmaj_r};
    q_fin  = quo_r[SW-1:0];
    s_fin  = (dmaj_r == '0) ? '0 : (neg_r ? SW'(-q_fin) : q_fin);
    s_fin_ext = {{(IW-SW){s_fin[SW-1]}}, s_fin};
    slope_ext = {{(IW-SW){slope_r[SW-1]}}, slope_r};
    pos_inc   = pos_r + PW'(1);
    out_free  = !out_valid_r || out_port.ready;
  end

  // pick the pixel for the current output slot
  always_comb begin
    maj = tpos_r;
    mnr = ip_r;
    cov = COV_ONE - {1'b0, fr_r};
    pix_last = 1'b0;
    if (is_start_r) begin
      case (k_r)
        2'd0: begin maj = PW'(a0_r); mnr = PW'(b0_r);          cov = COV_HALF; end
        2'd1: begin maj = PW'(a0_r); mnr = PW'(b0_r) + PW'(1); cov = '0;       end
        2'd2: begin maj = PW'(a1_r); mnr = PW'(b1_r);          cov = COV_HALF; end
        default: begin
          maj = PW'(a1_r); mnr = PW'(b1_r) + PW'(1); cov = '0; pix_last = !active_r;
        end
      endcase
      slot_done = k_r == 2'd3;
    end else begin
      if (k_r != 2'd0) begin
        mnr = ip_r + PW'(1);
        cov = {1'b0, fr_r};
        pix_last = tlast_r;
      end
      slot_done = k_r == 2'd1;
    end
    if (cov > COV_ONE) cov = COV_ONE;
    prod_r = (KW+CVW)'(red_r)   * (KW+CVW)'(cov);
    prod_g = (KW+CVW)'(green_r) * (KW+CVW)'(cov);
    prod_b = (KW+CVW)'(blue_r)  * (KW+CVW)'(cov);
  end

  assign cmd_port.ready      = state_r == ST_IDLE;
  assign out_port.valid      = out_valid_r;
  assign out_port.pixel_x    = px_r;
  assign out_port.pixel_y    = py_r;
  assign out_port.red_out    = ro_r;
  assign out_port.green_out  = go_r;
  assign out_port.blue_out   = bo_r;
  assign out_port.last_pixel = lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      steep_r     <= 1'b0;
      pos_r       <= '0;
      stop_r      <= '0;
      icpt_r      <= '0;
      slope_r     <= '0;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      is_start_r  <= 1'b0;
      k_r         <= 2'd0;
    end else begin
      // drop a taken word; while emitting, the slot logic owns the valid flag
      if (state_r != ST_EMIT && out_port.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (cmd_port.valid) begin
            if (cmd_port.is_start) begin
              steep_r <= cmd_port.steep;
              a0_r    <= cmd_port.a0;
              b0_r    <= cmd_port.b0;
              a1_r    <= cmd_port.a1;
              b1_r    <= cmd_port.b1;
              dmaj_r  <= cmd_port.dmaj;
              neg_r   <= cmd_port.dmin_neg;
              red_r   <= cmd_port.red;
              green_r <= cmd_port.green;
              blue_r  <= cmd_port.blue;
              rem_r   <= '0;
              quo_r   <= {cmd_port.dmin_abs, {FRAC_BITS{1'b0}}};
              cnt_r   <= CNTW'(DW);
              state_r <= ST_DIV;
            end else if (!active_r || pos_r >= stop_r) begin
              active_r <= 1'b0;
            end else begin
              tpos_r  <= pos_r;
              ip_r    <= icpt_r[IW-1:FRAC_BITS];
              fr_r    <= icpt_r[FRAC_BITS-1:0];
              icpt_r  <= icpt_r + slope_ext;
              pos_r   <= pos_inc;
              tlast_r <= pos_inc >= stop_r;
              if (pos_inc >= stop_r) active_r <= 1'b0;
              is_start_r <= 1'b0;
              k_r     <= 2'd0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          if (cnt_r != '0) begin
            rem_r <= qbit ? rem_sh - {1'b0, dmaj_r} : rem_sh;
            quo_r <= {quo_r[DW-2:0], qbit};
            cnt_r <= cnt_r - CNTW'(1);
          end else begin
            slope_r  <= s_fin;
            icpt_r   <= {PW'(b0_r), {FRAC_BITS{1'b0}}} + s_fin_ext;
            pos_r    <= PW'(a0_r) + PW'(1);
            stop_r   <= PW'(a1_r);
            active_r <= (PW'(a0_r) + PW'(1)) < PW'(a1_r);
            is_start_r <= 1'b1;
            k_r      <= 2'd0;
            state_r  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            px_r <= steep_r ? mnr : maj;
            py_r <= steep_r ? maj : mnr;
            ro_r <= prod_r[FRAC_BITS +: KW];
            go_r <= prod_g[FRAC_BITS +: KW];
            bo_r <= prod_b[FRAC_BITS +: KW];
            lo_r <= pix_last;
            k_r  <= k_r + 2'd1;
            if (slot_done) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/antialiased_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Anti-aliased line rasterizer, top level. Depends on alr_pkg, alr_if,
// alr_front and alr_back.
//
// Channels: in_port carries request words (start a line with two endpoints
// and a color, or tick for the next interior pixel pair); out_port carries
// pixel words (position, coverage-scaled color, last-pixel flag). Both use
// valid/ready; a word moves at a clock edge where both are high.
//
// A start word yields four pixel words (both endpoint pairs); a tick yields
// two, or none when no line is active. The front queues up to two classified
// words, so input keeps flowing while the back end works or output stalls.
//
// Sequence: a start runs the one-bit-per-cycle gradient divider, then sends its
// four pixel words; a tick steps the intercept, then sends its pair. Pixels go
// out one per cycle through the output register while out_port.ready is high.
//
// Reset (synchronous, rst_n low) empties the queue, drops any pending pixel
// word and ends the active line. When out_port.ready is low the output word
// holds, the back end waits, and the queue fills, then in_port.ready drops.
module antialiased_line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16,
  parameter int COLOR_BITS = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  alr_in_if.sink      in_port,
  alr_out_if.source   out_port
);

  // classified words between front and back
  alr_cmd_if #(.COORD_BITS(COORD_BITS), .COLOR_BITS(COLOR_BITS)) cmd_ch ();

  alr_front #(
    .COORD_BITS(COORD_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_port),
    .cmd_port (cmd_ch.source)
  );

  alr_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .COLOR_BITS(COLOR_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_port (cmd_ch.sink),
    .out_port (out_port)
  );

endmodule
`default_nettype wire

// File: sv/alr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on alr_pkg and antialiased_line_rasterizer.
module alr_port_checks #(
  parameter int COORD_BITS = 12,
  parameter int COLOR_BITS = 8
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  in_req_type,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [COORD_BITS:0]   out_pixel_x,
  input wire [COORD_BITS:0]   out_pixel_y,
  input wire [COLOR_BITS-1:0] out_red,
  input wire [COLOR_BITS-1:0] out_green,
  input wire [COLOR_BITS-1:0] out_blue,
  input wire                  out_last
);

  logic seen_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) seen_start_r <= 1'b0;
    else if (in_valid && in_ready && in_req_type == alr_pkg::REQ_START)
      seen_start_r <= 1'b1;
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel word withdrawn while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_x) && $stable(out_pixel_y) &&
      $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_last))
    else $error("pixel word changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel word pending after reset");

  a_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_start_r)
    else $error("pixel word without any start word");

endmodule

bind antialiased_line_rasterizer alr_port_checks #(
  .COORD_BITS(COORD_BITS),
  .COLOR_BITS(COLOR_BITS)
) u_alr_port_checks (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_port.valid),
  .in_ready    (in_port.ready),
  .in_req_type (in_port.req_type),
  .out_valid   (out_port.valid),
  .out_ready   (out_port.ready),
  .out_pixel_x (out_port.pixel_x),
  .out_pixel_y (out_port.pixel_y),
  .out_red     (out_port.red_out),
  .out_green   (out_port.green_out),
  .out_blue    (out_port.blue_out),
  .out_last    (out_port.last_pixel)
);
`default_nettype wire
